// ===== design/uvs_pkg.sv =====
// shared constants, types and helper functions of the uv sphere vertex generator
package uvs_pkg;

    localparam int MAX_DIVISIONS = 1024;
    localparam int CNT_W         = 11;
    localparam int IDX_W         = 11;
    localparam int RAD_W         = 16;
    localparam int NUM_W         = 29;
    localparam int DIV_STEPS     = 19;
    localparam int QUO_W         = DIV_STEPS;
    localparam int LANES         = 4;
    localparam int ANG_W         = 18;
    localparam int Z_W           = 17;
    localparam int NRM_W         = 16;
    localparam int POS_W         = 17;
    localparam int TEX_W         = 17;
    localparam int ADDR_W        = 4;

    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 136;

    localparam logic [Z_W-1:0]  QUARTER = 17'h10000;
    localparam logic [16:0]     POLY_A  = 17'd102944;
    localparam logic [15:0]     POLY_B  = 16'd42048;
    localparam logic [12:0]     POLY_C  = 13'd4640;

    localparam logic [ADDR_W-1:0] ADDR_SLICE_COUNT   = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_STACK_COUNT   = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_SPHERE_RADIUS = 4'h8;

    localparam logic [CNT_W-1:0] RESET_SLICE_COUNT   = 11'd16;
    localparam logic [CNT_W-1:0] RESET_STACK_COUNT   = 11'd16;
    localparam logic [RAD_W-1:0] RESET_SPHERE_RADIUS = 16'd256;

    localparam int LANE_PHI   = 0;
    localparam int LANE_THETA = 1;
    localparam int LANE_TEXU  = 2;
    localparam int LANE_TEXV  = 3;

    // pipeline stage numbers
    localparam int ST_IN   = 0;
    localparam int ST_T0   = DIV_STEPS + 1;
    localparam int ST_T1   = ST_T0 + 1;
    localparam int ST_T2   = ST_T0 + 2;
    localparam int ST_T3   = ST_T0 + 3;
    localparam int ST_M0   = ST_T0 + 4;
    localparam int ST_M1   = ST_T0 + 5;
    localparam int NSTAGE  = ST_M1 + 1;
    localparam int NTEX    = ST_M1 - ST_T0 + 1;

    typedef logic [NUM_W-1:0] num_t;
    typedef logic [QUO_W-1:0] quo_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (c > CNT_W'(MAX_DIVISIONS)) begin
            r = CNT_W'(MAX_DIVISIONS);
        end
        return r;
    endfunction

    // shift right by 14, rounding half away from zero
    function automatic logic signed [19:0] round_shift14(input logic signed [33:0] v);
        logic [33:0] mag;
        logic [33:0] sum;
        logic [19:0] sh;
        mag = v[33] ? 34'(-v) : 34'(v);
        sum = mag + 34'd8192;
        sh  = sum[33:14];
        return v[33] ? $signed(20'(-sh)) : $signed(sh);
    endfunction

endpackage

// ===== design/uv_sphere_vertex_generator.sv =====
// uv sphere vertex generator: index pair in, normal, position and texture coordinate out
//
// One vertex per grid point (stack, slice) of a uv sphere. The block takes one beat per
// cycle when the output side does not stall; each beat passes through the input stage, the
// 19-step long-division pipeline that turns the indices into angles and texture coordinates,
// four polynomial stages for sine and cosine and two multiply stages for normal and
// position before it is presented on the output. A stall on the output side is absorbed
// by empty pipeline stages first, so the input keeps taking beats until the pipeline is
// full. Counts of zero act as one and counts above 1024 act as 1024; indices are clamped
// to the count.
// Registers (APB): slice_count at 0x0, stack_count at 0x4, sphere_radius at 0x8; write
// them only while no vertex is in flight.
module uv_sphere_vertex_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // stack_index[10:0], slice_index[21:11], zero fill
    input  logic [uvs_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // normal_x, normal_y, normal_z, pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
    output logic [uvs_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [uvs_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import uvs_pkg::*;

    logic [CNT_W-1:0] slice_count_reg;
    logic [CNT_W-1:0] stack_count_reg;
    logic [RAD_W-1:0] sphere_radius_reg;
    logic [CNT_W-1:0] cs;
    logic [CNT_W-1:0] cl;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    num_t div_rem_reg [0:DIV_STEPS][LANES];
    quo_t div_quo_reg [0:DIV_STEPS][LANES];
    num_t div_rem_next [1:DIV_STEPS][LANES];
    quo_t div_quo_next [1:DIV_STEPS][LANES];

    logic [IDX_W-1:0] idx_i;
    logic [IDX_W-1:0] idx_j;

    logic [ANG_W-1:0] ang [LANES];
    logic [Z_W-1:0]   z_next [LANES];
    logic [Z_W-1:0]   z2_next [LANES];
    logic [Z_W-1:0]   t0_z_reg [LANES];
    logic [Z_W-1:0]   t0_z2_reg [LANES];
    logic             t0_neg_reg [LANES];
    logic [Z_W-1:0]   t1_z_reg [LANES];
    logic [Z_W-1:0]   t1_z2_reg [LANES];
    logic             t1_neg_reg [LANES];
    logic [15:0]      t1_r_reg [LANES];
    logic [Z_W-1:0]   t2_z_reg [LANES];
    logic             t2_neg_reg [LANES];
    logic [16:0]      t2_r_reg [LANES];
    logic signed [NRM_W-1:0] t3_m_reg [LANES];

    logic signed [NRM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [NRM_W-1:0] nx_m1_reg, ny_m1_reg, nz_m1_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic [TEX_W-1:0] texu_reg [NTEX];
    logic [TEX_W-1:0] texv_reg [NTEX];

    logic wr_en;

    assign cs = eff_count(stack_count_reg);
    assign cl = eff_count(slice_count_reg);

    // config port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_count_reg   <= RESET_SLICE_COUNT;
            stack_count_reg   <= RESET_STACK_COUNT;
            sphere_radius_reg <= RESET_SPHERE_RADIUS;
        end else if (wr_en) begin
            case (paddr)
                ADDR_SLICE_COUNT:   slice_count_reg   <= pwdata[CNT_W-1:0];
                ADDR_STACK_COUNT:   stack_count_reg   <= pwdata[CNT_W-1:0];
                ADDR_SPHERE_RADIUS: sphere_radius_reg <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_SLICE_COUNT:   prdata = 32'(slice_count_reg);
            ADDR_STACK_COUNT:   prdata = 32'(stack_count_reg);
            ADDR_SPHERE_RADIUS: prdata = 32'(sphere_radius_reg);
            default:            prdata = '0;
        endcase
    end

    // stage enables: a stage loads when it is empty or its successor moves
    always_comb begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE-2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[ST_IN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[ST_IN]) begin
                valid_reg[ST_IN] <= s_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // input stage: clamp and form numerators
    always_comb begin
        idx_i = s_tdata[IDX_W-1:0];
        idx_j = s_tdata[2*IDX_W-1:IDX_W];
        if (idx_i > cs) begin
            idx_i = cs;
        end
        if (idx_j > cl) begin
            idx_j = cl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            div_rem_reg[0][LANE_PHI]   <= (num_t'(idx_i) << 17) + num_t'(cs >> 1);
            div_rem_reg[0][LANE_THETA] <= (num_t'(idx_j) << 18) + num_t'(cl >> 1);
            div_rem_reg[0][LANE_TEXU]  <= (num_t'(idx_j) << 16) + num_t'(cl >> 1);
            div_rem_reg[0][LANE_TEXV]  <= (num_t'(idx_i) << 16) + num_t'(cs >> 1);
            for (int l = 0; l < LANES; l++) begin
                div_quo_reg[0][l] <= '0;
            end
        end
    end

    // long division, one quotient bit per stage
    always_comb begin
        num_t sub;
        for (int d = 1; d <= DIV_STEPS; d++) begin
            for (int l = 0; l < LANES; l++) begin
                if (l == LANE_PHI || l == LANE_TEXV) begin
                    sub = num_t'(cs) << (DIV_STEPS - d);
                end else begin
                    sub = num_t'(cl) << (DIV_STEPS - d);
                end
                div_rem_next[d][l] = div_rem_reg[d-1][l];
                div_quo_next[d][l] = div_quo_reg[d-1][l];
                if (div_rem_reg[d-1][l] >= sub) begin
                    div_rem_next[d][l] = div_rem_reg[d-1][l] - sub;
                    div_quo_next[d][l][DIV_STEPS-d] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int d = 1; d <= DIV_STEPS; d++) begin
            if (en[d]) begin
                for (int l = 0; l < LANES; l++) begin
                    div_rem_reg[d][l] <= div_rem_next[d][l];
                    div_quo_reg[d][l] <= div_quo_next[d][l];
                end
            end
        end
    end

    // angles: sin phi, cos phi, sin theta, cos theta
    always_comb begin
        logic [Z_W+Z_W-1:0] zz;
        ang[0] = div_quo_reg[DIV_STEPS][LANE_PHI][ANG_W-1:0];
        ang[1] = ang[0] + ANG_W'(QUARTER);
        ang[2] = div_quo_reg[DIV_STEPS][LANE_THETA][ANG_W-1:0];
        ang[3] = ang[2] + ANG_W'(QUARTER);
        for (int l = 0; l < LANES; l++) begin
            z_next[l]  = ang[l][16] ? (QUARTER - Z_W'(ang[l][15:0])) : Z_W'(ang[l][15:0]);
            zz         = z_next[l] * z_next[l];
            z2_next[l] = zz[32:16];
        end
    end

    always_ff @(posedge aclk) begin
        logic [29:0] p1;
        logic [32:0] p2;
        logic [33:0] p3;
        logic [17:0] pq;
        logic [15:0] mg;
        for (int l = 0; l < LANES; l++) begin
            if (en[ST_T0]) begin
                t0_z_reg[l]   <= z_next[l];
                t0_z2_reg[l]  <= z2_next[l];
                t0_neg_reg[l] <= ang[l][17];
            end
            if (en[ST_T1]) begin
                p1 = POLY_C * t0_z2_reg[l];
                t1_r_reg[l]   <= POLY_B - 16'(p1[29:16]);
                t1_z_reg[l]   <= t0_z_reg[l];
                t1_z2_reg[l]  <= t0_z2_reg[l];
                t1_neg_reg[l] <= t0_neg_reg[l];
            end
            if (en[ST_T2]) begin
                p2 = t1_r_reg[l] * t1_z2_reg[l];
                t2_r_reg[l]   <= POLY_A - p2[32:16];
                t2_z_reg[l]   <= t1_z_reg[l];
                t2_neg_reg[l] <= t1_neg_reg[l];
            end
            if (en[ST_T3]) begin
                p3 = t2_r_reg[l] * t2_z_reg[l];
                pq = p3[33:16] + 18'd2;
                mg = 16'(pq[17:2]);
                t3_m_reg[l] <= t2_neg_reg[l] ? $signed(16'(-mg)) : $signed(mg);
            end
        end
    end

    // normal and position
    always_ff @(posedge aclk) begin
        logic signed [19:0] r0;
        logic signed [19:0] r1;
        logic signed [19:0] r2;
        logic signed [19:0] r3;
        logic signed [19:0] r4;
        logic signed [RAD_W:0] rad;
        if (en[ST_M0]) begin
            r0 = round_shift14(34'(t3_m_reg[0] * t3_m_reg[3]));
            r1 = round_shift14(34'(t3_m_reg[0] * t3_m_reg[2]));
            nx_reg <= r0[NRM_W-1:0];
            ny_reg <= t3_m_reg[1];
            nz_reg <= r1[NRM_W-1:0];
        end
        if (en[ST_M1]) begin
            rad = $signed({1'b0, sphere_radius_reg});
            r2 = round_shift14(34'(nx_reg * rad));
            r3 = round_shift14(34'(ny_reg * rad));
            r4 = round_shift14(34'(nz_reg * rad));
            px_reg <= r2[POS_W-1:0];
            py_reg <= r3[POS_W-1:0];
            pz_reg <= r4[POS_W-1:0];
            nx_m1_reg <= nx_reg;
            ny_m1_reg <= ny_reg;
            nz_m1_reg <= nz_reg;
        end
    end

    // texture coordinates ride along
    always_ff @(posedge aclk) begin
        if (en[ST_T0]) begin
            texu_reg[0] <= div_quo_reg[DIV_STEPS][LANE_TEXU][TEX_W-1:0];
            texv_reg[0] <= div_quo_reg[DIV_STEPS][LANE_TEXV][TEX_W-1:0];
        end
        for (int k = 1; k < NTEX; k++) begin
            if (en[ST_T0+k]) begin
                texu_reg[k] <= texu_reg[k-1];
                texv_reg[k] <= texv_reg[k-1];
            end
        end
    end

    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = {3'b000, texv_reg[NTEX-1], texu_reg[NTEX-1], pz_reg, py_reg, px_reg,
                       nz_m1_reg, ny_m1_reg, nx_m1_reg};

`ifndef SYNTH
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[NSTAGE-1] |-> s_tready)
        else $error("input stalled with empty output stage");

    a_pole_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && texv_reg[NTEX-1] == '0) |-> (ny_m1_reg == 16'sd16384))
        else $error("top pole vertex without unit y normal");
`endif

endmodule
